// ===== hw/rtl/sketch_heavy_key_update_defines.svh =====
// Assertion macros shared by the sketch update RTL.
`ifndef SKETCH_HEAVY_KEY_UPDATE_DEFINES_SVH
`define SKETCH_HEAVY_KEY_UPDATE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SHKU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define SHKU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/shku_pkg.sv =====
// Shared constants, types and helpers of the sketch update block.
`timescale 1ns / 1ps
package shku_pkg;
  localparam int ROWS      = 4;
  localparam int COLUMNS   = 1024;
  localparam int KEY_BYTES = 8;
  localparam int ROW_W     = 2;   // row index bits
  localparam int RCNT_W    = 3;   // row count bits
  localparam int COL_W     = 10;  // column index bits
  localparam int SLOTS     = ROWS * COLUMNS;
  localparam int SLOT_W    = ROW_W + COL_W;
  localparam int WID_W     = 11;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int LEN_W     = 4;

  localparam logic [31:0] MAXV = 32'hffffffff;
  localparam logic [31:0] MM_M = 32'h5bd1e995;

  localparam logic CFG_ROWS  = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    logic [31:0]      cnt;
  } slot_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [31:0]      seed;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } hash_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAXV : s[31:0];
  endfunction

  // Keep the low len bytes of the key, len already in 1..KEY_BYTES.
  function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_W-1:0] k,
                                                input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < len) m[8*b +: 8] = 8'hff;
    end
    return k & m;
  endfunction
endpackage

// ===== hw/rtl/sketch_heavy_key_update.sv =====
// Per update: for each row probed, a hash, a remainder pass and a slot read; a miss
// with a nonzero counter after the add takes one more remainder pass for the replacement
// draw. The bit-serial remainder unit dominates; one update is in flight at a time.
// The next beat is taken once the result is registered.
// Reset (rst, synchronous): a clearing pass over all 4096 slots zeroes the slot memory,
// s_tready stays low meanwhile; registers return to 4 rows and 1024 columns.
`timescale 1ns / 1ps
`include "sketch_heavy_key_update_defines.svh"
module sketch_heavy_key_update (
  input  logic         clk,
  input  logic         rst,
  // configuration writes
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [10:0]  cfg_data,
  // update beats in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // key_value[63:0], key_length[67:64], increment[99:68],
                                 // random_word[130:100], zero fill
  // result beats out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata   // hit[0], row_used[2:1], column_used[12:3],
                                 // counter_after[44:13], replaced[45], total_count[77:46],
                                 // zero fill
);
  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_HASH   = 10'b0000000100,
    ST_MODH   = 10'b0000001000,
    ST_READ   = 10'b0000010000,
    ST_EVAL   = 10'b0000100000,
    ST_CHOOSE = 10'b0001000000,
    ST_MODR   = 10'b0010000000,
    ST_WRITE  = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic [shku_pkg::RCNT_W-1:0] rows_in_use;
  logic [shku_pkg::WID_W-1:0]  row_width;
  logic [31:0]                 grand_total;

  // accepted update, clamped at accept
  logic [shku_pkg::KEY_W-1:0]  key_r;
  logic [shku_pkg::LEN_W-1:0]  len_r;
  logic [31:0]                 inc_r;
  logic [30:0]                 rnd_r;
  logic [shku_pkg::RCNT_W-1:0] rows_r;
  logic [shku_pkg::WID_W-1:0]  wid_r;

  // probe walk and running minimum
  logic [shku_pkg::ROW_W-1:0]  row_r;
  logic [shku_pkg::COL_W-1:0]  col_r;
  logic [shku_pkg::ROW_W-1:0]  min_row;
  logic [shku_pkg::COL_W-1:0]  min_col;
  shku_pkg::slot_t             base;      // slot read at the chosen place
  logic [31:0]                 cnt_new;
  logic                        hit_r;
  logic                        repl_r;
  logic [shku_pkg::ROW_W-1:0]  out_row;
  logic [shku_pkg::COL_W-1:0]  out_col;

  logic [shku_pkg::SLOT_W-1:0] clr_addr;
  logic                        hash_go;
  logic                        mod_go;

  // unpacked input beat
  logic [shku_pkg::KEY_W-1:0]  in_key;
  logic [shku_pkg::LEN_W-1:0]  in_len;
  logic [shku_pkg::LEN_W-1:0]  len_c;
  logic [31:0]                 in_inc;
  logic [30:0]                 in_rnd;
  logic                        in_beat;

  // memory
  logic                        ram_we;
  logic [shku_pkg::SLOT_W-1:0] ram_waddr;
  shku_pkg::slot_t             ram_wdata;
  shku_pkg::slot_t             ram_rdata;

  shku_pkg::hash_req_t hreq;
  shku_pkg::hash_rsp_t hrsp;
  shku_pkg::mod_req_t  mreq;
  shku_pkg::mod_rsp_t  mrsp;

  logic                        match;
  logic                        last_row;
  logic [31:0]                 choose_cnt;
  logic                        out_load;

  assign in_key = s_tdata[63:0];
  assign in_len = s_tdata[67:64];
  assign in_inc = s_tdata[99:68];
  assign in_rnd = s_tdata[130:100];

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;

  // result register loads when empty or being drained this cycle
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // zero length counts as one byte, anything over the key size as the full key
  always_comb begin
    priority if (in_len == '0) len_c = shku_pkg::LEN_W'(1);
    else if (in_len > shku_pkg::LEN_W'(shku_pkg::KEY_BYTES))
      len_c = shku_pkg::LEN_W'(shku_pkg::KEY_BYTES);
    else len_c = in_len;
  end

  assign match    = (ram_rdata.len == len_r) && (ram_rdata.key == key_r);
  assign last_row = (shku_pkg::RCNT_W'(row_r) + shku_pkg::RCNT_W'(1)) >= rows_r;
  assign choose_cnt = shku_pkg::sat_add(base.cnt, inc_r);

  // hash and remainder units
  assign hreq.start = hash_go;
  assign hreq.key   = key_r;
  assign hreq.len   = len_r;
  assign hreq.seed  = 32'(row_r);

  assign mreq.start    = mod_go;
  assign mreq.dividend = (state == ST_MODR) ? {1'b0, rnd_r} : hrsp.value;
  assign mreq.divisor  = (state == ST_MODR) ? cnt_new : 32'(wid_r);

  shku_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  shku_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // slot memory; address is row * COLUMNS + column, COLUMNS a power of two
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == ST_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = {out_row, out_col};
      ram_wdata.cnt = cnt_new;
      ram_wdata.key = repl_r ? key_r : base.key;
      ram_wdata.len = repl_r ? len_r : base.len;
    end
  end

  shku_ram #(
    .WIDTH ($bits(shku_pkg::slot_t)),
    .DEPTH (shku_pkg::SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({row_r, col_r}),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= shku_pkg::RCNT_W'(shku_pkg::ROWS);
      row_width   <= shku_pkg::WID_W'(shku_pkg::COLUMNS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        shku_pkg::CFG_ROWS:  rows_in_use <= cfg_data[shku_pkg::RCNT_W-1:0];
        shku_pkg::CFG_WIDTH: row_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      grand_total <= '0;
      hash_go     <= 1'b0;
      mod_go      <= 1'b0;
      m_tvalid    <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      hash_go <= 1'b0;
      mod_go  <= 1'b0;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + shku_pkg::SLOT_W'(1);
          if (clr_addr == shku_pkg::SLOT_W'(shku_pkg::SLOTS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_beat) begin
            key_r       <= shku_pkg::key_mask(in_key, len_c);
            len_r       <= len_c;
            inc_r       <= in_inc;
            rnd_r       <= in_rnd;
            grand_total <= shku_pkg::sat_add(grand_total, in_inc);
            priority if (rows_in_use == '0) rows_r <= shku_pkg::RCNT_W'(1);
            else if (rows_in_use > shku_pkg::RCNT_W'(shku_pkg::ROWS))
              rows_r <= shku_pkg::RCNT_W'(shku_pkg::ROWS);
            else rows_r <= rows_in_use;
            priority if (row_width == '0) wid_r <= shku_pkg::WID_W'(1);
            else if (row_width > shku_pkg::WID_W'(shku_pkg::COLUMNS))
              wid_r <= shku_pkg::WID_W'(shku_pkg::COLUMNS);
            else wid_r <= row_width;
            row_r   <= '0;
            hit_r   <= 1'b0;
            repl_r  <= 1'b0;
            hash_go <= 1'b1;
            state   <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hrsp.done) begin
            mod_go <= 1'b1;
            state  <= ST_MODH;
          end
        end
        ST_MODH: begin
          if (mrsp.done) begin
            col_r <= mrsp.rem[shku_pkg::COL_W-1:0];
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          if (match) begin
            hit_r   <= 1'b1;
            out_row <= row_r;
            out_col <= col_r;
            base    <= ram_rdata;
            cnt_new <= shku_pkg::sat_add(ram_rdata.cnt, inc_r);
            state   <= ST_WRITE;
          end else begin
            // first probed slot with the smallest counter wins
            if (row_r == '0 || ram_rdata.cnt < base.cnt) begin
              base    <= ram_rdata;
              min_row <= row_r;
              min_col <= col_r;
            end
            if (last_row) begin
              state <= ST_CHOOSE;
            end else begin
              row_r   <= row_r + shku_pkg::ROW_W'(1);
              hash_go <= 1'b1;
              state   <= ST_HASH;
            end
          end
        end
        ST_CHOOSE: begin
          cnt_new <= choose_cnt;
          out_row <= min_row;
          out_col <= min_col;
          // zero counter after the add: no draw, no replacement
          if (choose_cnt != '0) begin
            mod_go <= 1'b1;
            state  <= ST_MODR;
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_MODR: begin
          if (mrsp.done) begin
            repl_r <= (mrsp.rem < inc_r);
            state  <= ST_WRITE;
          end
        end
        ST_WRITE: state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            m_tdata <= {2'b00, grand_total, repl_r, cnt_new, out_col, out_row, hit_r};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // memory is written only by the clearing pass or the write-back step
  `SHKU_ASSERT_NOW(a_ram_we_state, ram_we, (state == ST_CLEAR) || (state == ST_WRITE), "stray write")
  // a hit never reports a replacement
  `SHKU_ASSERT_NOW(a_hit_no_repl, m_tvalid, !(m_tdata[0] && m_tdata[45]), "hit flagged replaced")
  // the remainder unit is never restarted while busy
  `SHKU_ASSERT_NOW(a_mod_no_overlap, mreq.start, !mrsp.busy, "remainder unit restarted")
  // a remainder pass always leads to the next step
  `SHKU_ASSERT_NEXT(a_modr_leaves, (state == ST_MODR) && mrsp.done, state == ST_WRITE, "draw lost")
endmodule

// ===== hw/rtl/shku_ram.sv =====
// Generic single-clock RAM, one write and one registered read port.
`timescale 1ns / 1ps
module shku_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/shku_hash.sv =====
// MurmurHash2 sequencer over one shared 32x32 multiplier.
`timescale 1ns / 1ps
module shku_hash (
  input  logic                clk,
  input  logic                rst,
  input  shku_pkg::hash_req_t req,
  output shku_pkg::hash_rsp_t rsp
);
  typedef enum logic [6:0] {
    H_IDLE = 7'b0000001,
    H_W1   = 7'b0000010,
    H_W2   = 7'b0000100,
    H_W3   = 7'b0001000,
    H_TAIL = 7'b0010000,
    H_F1   = 7'b0100000,
    H_F2   = 7'b1000000
  } hstate_t;

  hstate_t     state;
  logic [31:0] h;
  logic [31:0] w;
  logic [1:0]  wi;       // words consumed
  logic        done;
  logic [31:0] word;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [3:0]  rem_next; // bytes left after the current word

  assign word     = wi[0] ? req.key[63:32] : req.key[31:0];
  assign rem_next = req.len - {wi + 2'd1, 2'b00};

  always_comb begin
    unique case (state)
      H_W1:    mul_a = word;
      H_W2:    mul_a = w ^ (w >> 24);
      H_W3:    mul_a = h;
      H_TAIL:  mul_a = h ^ word;
      H_F1:    mul_a = h ^ (h >> 13);
      default: mul_a = h;
    endcase
  end

  assign prod = mul_a * shku_pkg::MM_M;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (req.start) begin
            h  <= req.seed ^ {28'd0, req.len};
            wi <= 2'd0;
            priority if (req.len >= 4'd4) state <= H_W1;
            else state <= H_TAIL;
          end
        end
        H_W1: begin
          w     <= prod;
          state <= H_W2;
        end
        H_W2: begin
          w     <= prod;
          state <= H_W3;
        end
        H_W3: begin
          h  <= prod ^ w;
          wi <= wi + 2'd1;
          priority if (rem_next >= 4'd4) state <= H_W1;
          else if (rem_next != 4'd0) state <= H_TAIL;
          else state <= H_F1;
        end
        H_TAIL: begin
          h     <= prod;
          state <= H_F1;
        end
        H_F1: begin
          h     <= prod;
          state <= H_F2;
        end
        H_F2: begin
          h     <= h ^ (h >> 15);
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.value = h;
endmodule

// ===== hw/rtl/shku_mod.sv =====
// Restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module shku_mod (
  input  logic               clk,
  input  logic               rst,
  input  shku_pkg::mod_req_t req,
  output shku_pkg::mod_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [31:0] rem;
  logic [31:0] div;
  logic [32:0] t;
  logic [32:0] d;

  assign t = {rem, q[31]};
  assign d = t - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        q    <= req.dividend;
        rem  <= '0;
        div  <= req.divisor;
      end else if (busy) begin
        rem <= d[32] ? t[31:0] : d[31:0];
        q   <= {q[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.rem  = rem;
endmodule
